// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    // Operation codes carried on s_tuser.
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_DEQUEUE = 1'b1;

    // Result status codes carried on m_tuser.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } spq_status_t;

    // Shift command broadcast from the top level to every cell.
    typedef struct packed {
        logic enq;  // insert the new entry, shifting lower-priority entries back
        logic deq;  // pop the head, shifting every entry forward
    } spq_op_t;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIO_BITS = 4,
    parameter int TAG_BITS  = 16
) (
    input  logic                 aclk,
    input  spq_op_t              op,
    input  logic                 occupied,
    input  logic                 left_behind,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [TAG_BITS-1:0]  left_tag,
    input  logic [PRIO_BITS-1:0] right_prio,
    input  logic [TAG_BITS-1:0]  right_tag,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic [TAG_BITS-1:0]  new_tag,
    output logic                 behind,
    output logic [PRIO_BITS-1:0] prio,
    output logic [TAG_BITS-1:0]  tag
);

    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;

    // The new entry goes behind this cell when this cell holds an entry of
    // equal or higher priority. The sorted order makes this flag monotonic.
    assign behind = occupied && (prio_reg >= new_prio);

    always_comb begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (op.deq) begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end else if (op.enq && !behind) begin
            if (left_behind) begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end else begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign prio = prio_reg;
    assign tag  = tag_reg;

endmodule

// ----- rtl/stable_priority_queue.sv -----
// Channel | Direction | tvalid/tready | tdata (low bit up)                   | tuser
// s_      | in        | yes           | entry_priority, entry_tag            | func
// m_      | out       | yes           | out_priority, out_tag, occupancy     | status
//
// One beat is taken per clock cycle while s_tready is high; its result is registered
// and appears on m_ in the next cycle. Every cell compares its own priority with
// the incoming one and shifts in the same cycle, so the insert search and the shift happen together.
// aresetn is synchronous and active low; it empties the queue and the output.
// s_tready is low only while a result waits on m_ and m_tready is low.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 4,
    parameter int TAG_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // entry_priority, entry_tag, zero padding
    input  logic [((PRIO_BITS+TAG_BITS+7)/8)*8-1:0]  s_tdata,
    // func
    input  logic                                     s_tuser,

    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // out_priority, out_tag, occupancy, zero padding
    output logic [((PRIO_BITS+TAG_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]                               m_tuser
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int M_FIELDS = PRIO_BITS + TAG_BITS + CNT_BITS;
    localparam int M_BITS   = ((M_FIELDS + 7) / 8) * 8;

    // Unpack the input beat. The padding bits of s_tdata above the fields
    // are ignored.
    logic [PRIO_BITS-1:0] in_prio;
    logic [TAG_BITS-1:0]  in_tag;
    logic                 in_func;

    assign in_prio = s_tdata[PRIO_BITS-1:0];
    assign in_tag  = s_tdata[PRIO_BITS +: TAG_BITS];
    assign in_func = s_tuser;

    // The output register frees up when it is empty or being drained.
    logic m_tvalid_reg, m_tvalid_next;
    logic accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                full, empty;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);

    spq_op_t op;

    always_comb begin
        op.enq = accept && (in_func == FUNC_ENQUEUE) && !full;
        op.deq = accept && (in_func == FUNC_DEQUEUE) && !empty;
    end

    // The cell row. Entry 0 is the head of the queue.
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];
    logic [TAG_BITS-1:0]  cell_tag  [DEPTH];
    logic [DEPTH-1:0]     cell_behind;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 left_behind;
        logic [PRIO_BITS-1:0] left_prio, right_prio;
        logic [TAG_BITS-1:0]  left_tag, right_tag;

        if (i == 0) begin : g_head
            // Everything before the head counts as ahead of the new entry.
            assign left_behind = 1'b1;
            assign left_prio   = in_prio;
            assign left_tag    = in_tag;
        end else begin : g_mid
            assign left_behind = cell_behind[i-1];
            assign left_prio   = cell_prio[i-1];
            assign left_tag    = cell_tag[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            // The last cell falls out of the valid range on a pop.
            assign right_prio = cell_prio[i];
            assign right_tag  = cell_tag[i];
        end else begin : g_body
            assign right_prio = cell_prio[i+1];
            assign right_tag  = cell_tag[i+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .aclk        (aclk),
            .op          (op),
            .occupied    (CNT_BITS'(i) < count_reg),
            .left_behind (left_behind),
            .left_prio   (left_prio),
            .left_tag    (left_tag),
            .right_prio  (right_prio),
            .right_tag   (right_tag),
            .new_prio    (in_prio),
            .new_tag     (in_tag),
            .behind      (cell_behind[i]),
            .prio        (cell_prio[i]),
            .tag         (cell_tag[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (op.enq) begin
            count_next = count_reg + 1'b1;
        end else if (op.deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Result fields for the beat being accepted.
    spq_status_t          status_next;
    logic [PRIO_BITS-1:0] out_prio_next;
    logic [TAG_BITS-1:0]  out_tag_next;

    always_comb begin
        status_next   = STATUS_OK;
        out_prio_next = '0;
        out_tag_next  = '0;
        if (in_func == FUNC_ENQUEUE) begin
            if (full) begin
                status_next = STATUS_FULL;
            end
        end else begin
            if (empty) begin
                status_next = STATUS_EMPTY;
            end else begin
                out_prio_next = cell_prio[0];
                out_tag_next  = cell_tag[0];
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            count_reg    <= count_next;
        end
    end

    // Result payload holds until the next accepted beat.
    logic [M_BITS-1:0] m_tdata_reg;
    spq_status_t       status_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= M_BITS'({count_next, out_tag_next, out_prio_next});
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = status_reg;

endmodule

// ----- rtl/spq_checker.sv -----
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 4,
    parameter int TAG_BITS  = 16
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((PRIO_BITS+TAG_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    input logic [1:0] m_tuser
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int OCC_LSB  = PRIO_BITS + TAG_BITS;

    logic [CNT_BITS-1:0] occ;
    assign occ = m_tdata[OCC_LSB +: CNT_BITS];

    // Every accepted beat produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // A pending result is not dropped while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A dropped enqueue only happens with a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_FULL) |-> occ == CNT_BITS'(DEPTH))
        else $error("full status with a non-full queue");

    // An empty dequeue reports an empty queue and zero payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_EMPTY) |->
            occ == '0 && m_tdata[OCC_LSB-1:0] == '0)
        else $error("empty status with data");

    // Occupancy never exceeds the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= CNT_BITS'(DEPTH))
        else $error("occupancy above depth");

endmodule

bind stable_priority_queue spq_checker #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .TAG_BITS  (TAG_BITS)
) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/tb_stable_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 4;
    localparam int TAG_BITS  = 16;
    localparam int OCC_BITS  = $clog2(DEPTH + 1);
    localparam int S_BITS    = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_BITS    = ((PRIO_BITS + TAG_BITS + OCC_BITS + 7) / 8) * 8;

    // One request as it travels on the slave side.
    typedef struct packed {
        logic                 func;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } queue_request_t;

    // One answer as it travels on the master side.
    typedef struct packed {
        spq_status_t          status;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
        logic [OCC_BITS-1:0]  occ;
    } queue_answer_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // entry_priority, entry_tag, zero padding
    logic [S_BITS-1:0] s_tdata  = '0;
    // func
    logic              s_tuser  = FUNC_ENQUEUE;
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    // out_priority, out_tag, occupancy, zero padding
    logic [M_BITS-1:0] m_tdata;
    // status
    logic [1:0]        m_tuser;

    stable_priority_queue #(
        .DEPTH    (DEPTH),
        .PRIO_BITS(PRIO_BITS),
        .TAG_BITS (TAG_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 20 ns period; the first rising edge comes 10 ns into the run.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Requests waiting for the driver, and answers the queue still owes us.
    queue_request_t pending_requests[$];
    queue_answer_t  owed_answers[$];

    // Our own copy of the sorted store, head in slot zero.
    logic [PRIO_BITS-1:0] shadow_prio[DEPTH];
    logic [TAG_BITS-1:0]  shadow_tag[DEPTH];
    int                   shadow_count = 0;

    // Idle percentages for the current phase, set by the stimulus process.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Set at a rising edge when the slave side took a beat.
    logic s_beat_taken = 1'b0;

    int mismatch_count  = 0;
    int answers_checked = 0;
    int enqueue_count   = 0;
    int dequeue_count   = 0;
    int full_drops      = 0;
    int empty_pops      = 0;
    int peak_occupancy  = 0;

    // Apply one accepted request to the shadow store and return the answer
    // the queue must give. A new entry goes behind every stored entry of
    // equal or higher priority, which keeps equal priorities first in, first out.
    function automatic queue_answer_t apply_to_shadow(queue_request_t req);
        queue_answer_t ans;
        int pos;
        int k;
        ans.status = STATUS_OK;
        ans.prio   = '0;
        ans.tag    = '0;
        if (req.func == FUNC_ENQUEUE) begin
            enqueue_count++;
            if (shadow_count >= DEPTH) begin
                ans.status = STATUS_FULL;
                full_drops++;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= req.prio)
                    pos++;
                for (k = shadow_count; k > pos; k--) begin
                    shadow_prio[k] = shadow_prio[k-1];
                    shadow_tag[k]  = shadow_tag[k-1];
                end
                shadow_prio[pos] = req.prio;
                shadow_tag[pos]  = req.tag;
                shadow_count++;
            end
        end else begin
            dequeue_count++;
            if (shadow_count == 0) begin
                ans.status = STATUS_EMPTY;
                empty_pops++;
            end else begin
                ans.prio = shadow_prio[0];
                ans.tag  = shadow_tag[0];
                for (k = 1; k < shadow_count; k++) begin
                    shadow_prio[k-1] = shadow_prio[k];
                    shadow_tag[k-1]  = shadow_tag[k];
                end
                shadow_count--;
            end
        end
        if (shadow_count > peak_occupancy)
            peak_occupancy = shadow_count;
        ans.occ = shadow_count[OCC_BITS-1:0];
        return ans;
    endfunction

    task automatic add_enqueue(input logic [PRIO_BITS-1:0] prio,
                               input logic [TAG_BITS-1:0] tag);
        queue_request_t req;
        req.func = FUNC_ENQUEUE;
        req.prio = prio;
        req.tag  = tag;
        pending_requests.push_back(req);
    endtask

    // The payload of a dequeue is ignored by the queue, so it is left random.
    task automatic add_dequeue();
        queue_request_t req;
        req.func = FUNC_DEQUEUE;
        req.prio = PRIO_BITS'($urandom);
        req.tag  = TAG_BITS'($urandom);
        pending_requests.push_back(req);
    endtask

    // Random traffic in bursts of 32 beats. Each burst leans toward filling,
    // draining or balance so that the queue swings between full and empty,
    // and half of its priorities come from a narrow band so that ties are common.
    task automatic add_random_traffic(input int count);
        int unsigned enq_pct;
        int unsigned band_low;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
        enq_pct  = 50;
        band_low = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0) begin
                case ($urandom_range(2))
                    0: begin
                        enq_pct = 25;
                    end
                    1: begin
                        enq_pct = 50;
                    end
                    default: begin
                        enq_pct = 80;
                    end
                endcase
                band_low = $urandom_range(14);
            end
            if ($urandom_range(99) < enq_pct) begin
                if ($urandom_range(1) == 1)
                    prio = PRIO_BITS'($urandom_range(band_low + 1, band_low));
                else
                    prio = PRIO_BITS'($urandom);
                case ($urandom_range(7))
                    0: begin
                        tag = '0;
                    end
                    1: begin
                        tag = '1;
                    end
                    default: begin
                        tag = TAG_BITS'($urandom);
                    end
                endcase
                add_enqueue(prio, tag);
            end else begin
                add_dequeue();
            end
        end
    endtask

    // Block until every queued request has been taken and answered.
    // Sampled at the rising edge, where neither the queue nor s_tvalid moves.
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || s_tvalid || owed_answers.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: all inputs change at the falling edge. A beat that has not been
    // taken is held; otherwise the next request is shown or the line idles.
    always @(negedge aclk) begin
        queue_request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b1;
        end else begin
            if (!s_tvalid || s_beat_taken) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_BITS - PRIO_BITS - TAG_BITS){1'b0}}, req.tag, req.prio};
                    s_tuser  <= req.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: at each rising edge, check an answer beat against the oldest
    // owed answer, then predict the answer for a request beat taken now.
    always @(posedge aclk) begin
        queue_answer_t  got;
        queue_answer_t  want;
        queue_request_t req;
        if (!aresetn) begin
            s_beat_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = spq_status_t'(m_tuser);
                got.prio   = m_tdata[PRIO_BITS-1:0];
                got.tag    = m_tdata[PRIO_BITS +: TAG_BITS];
                got.occ    = m_tdata[PRIO_BITS + TAG_BITS +: OCC_BITS];
                answers_checked++;
                if (owed_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: answer with none owed: status %0d prio %0d tag %h occ %0d",
                                 $realtime, got.status, got.prio, got.tag, got.occ);
                end else begin
                    want = owed_answers.pop_front();
                    if (got.status !== want.status || got.prio !== want.prio ||
                        got.tag !== want.tag || got.occ !== want.occ) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: answer %0d differs: status %0d/%0d prio %0d/%0d ",
                                      "tag %h/%h occ %0d/%0d (expected/actual)"},
                                     $realtime, answers_checked, want.status, got.status,
                                     want.prio, got.prio, want.tag, got.tag,
                                     want.occ, got.occ);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req.func = s_tuser;
                req.prio = s_tdata[PRIO_BITS-1:0];
                req.tag  = s_tdata[PRIO_BITS +: TAG_BITS];
                owed_answers.push_back(apply_to_shadow(req));
            end
            s_beat_taken <= s_tvalid && s_tready;
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned send_pcts[4];
        int unsigned recv_pcts[4];
        send_pcts = '{0, 71, 0, 18};
        recv_pcts = '{0, 0, 71, 18};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening, with no idling: a dequeue from the empty queue,
        // a fill to capacity with ties at several priorities and both extreme
        // priorities and tags, an enqueue refused while full, then a few
        // dequeues and a refill behind an existing tie.
        add_dequeue();
        add_enqueue(4'd15, 16'hFFFF);
        add_enqueue(4'd0,  16'h0000);
        add_enqueue(4'd7,  16'h0001);
        add_enqueue(4'd7,  16'h0002);
        add_enqueue(4'd15, 16'h0003);
        add_enqueue(4'd0,  16'h0004);
        add_enqueue(4'd7,  16'h0005);
        add_enqueue(4'd8,  16'hAAAA);
        add_enqueue(4'd5,  16'h5555);
        add_enqueue(4'd15, 16'h0006);
        add_enqueue(4'd1,  16'h0007);
        add_enqueue(4'd7,  16'h0008);
        add_enqueue(4'd14, 16'h0009);
        add_enqueue(4'd2,  16'h000A);
        add_enqueue(4'd7,  16'h000B);
        add_enqueue(4'd0,  16'h000C);
        add_enqueue(4'd9,  16'h1234);
        add_dequeue();
        add_dequeue();
        add_dequeue();
        add_enqueue(4'd7,  16'hFFFF);
        wait_for_drain();

        // Random traffic, once per idling pattern: none, a slow sender,
        // a stalling receiver, then light idling on both sides.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            add_random_traffic(235);
            wait_for_drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Give a stray late answer time to show up before the verdict.
        repeat (8) @(posedge aclk);

        $display("Checked %0d answers over %0d enqueues (%0d refused as full) and %0d dequeues",
                 answers_checked, enqueue_count, full_drops, dequeue_count);
        $display("(%0d from an empty queue); peak occupancy %0d of %0d, %0d mismatches.",
                 empty_pops, peak_occupancy, DEPTH, mismatch_count);
        if (mismatch_count == 0 && owed_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (owed_answers.size() != 0)
                $display("%0d answers never arrived.", owed_answers.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: the slowest legal run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("Run did not finish within its time budget.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
verif/tb_stable_priority_queue.sv
